>>> hw/rtl/text_encoding_detector_unit_defines.svh
// Assertion macros used by the detector top-level RTL.
`ifndef TEXT_ENCODING_DETECTOR_UNIT_DEFINES_SVH
`define TEXT_ENCODING_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk, off while in reset.
`define TED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while in reset.
`define TED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ted_pkg.sv
package ted_pkg;

    // What one input word carries
    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_UTF8     = 2'd0,
        VERDICT_UTF8_BOM = 2'd1,
        VERDICT_SJIS     = 2'd2,
        VERDICT_UNDECOD  = 2'd3
    } verdict_t;

    // One word handed from the input register to the scanner
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data_byte;
    } step_t;

    localparam int BOM_LEN = 3;

    // Continuation byte window
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    // Byte order mark EF BB BF, one byte per position
    function automatic logic [7:0] bom_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBB;
            default: b = 8'hBF;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/ted_scan.sv
module ted_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  ted_pkg::step_t    step,
    output ted_pkg::verdict_t verdict
);

    logic [1:0] bom_cnt_reg, bom_cnt_next;
    logic       bom_ok_reg, bom_ok_next;
    logic [1:0] u8_pend_reg, u8_pend_next;
    logic [7:0] u8_lo_reg, u8_lo_next;
    logic [7:0] u8_hi_reg, u8_hi_next;
    logic       u8_ok_reg, u8_ok_next;
    logic       sj_trail_reg, sj_trail_next;
    logic       sj_ok_reg, sj_ok_next;

    logic [7:0] b;
    logic       has_bom;
    logic       utf8_good;
    logic       sjis_good;

    assign b = step.data_byte;

    // Per-byte state update for all three checks
    always_comb begin
        bom_cnt_next  = bom_cnt_reg;
        bom_ok_next   = bom_ok_reg;
        u8_pend_next  = u8_pend_reg;
        u8_lo_next    = u8_lo_reg;
        u8_hi_next    = u8_hi_reg;
        u8_ok_next    = u8_ok_reg;
        sj_trail_next = sj_trail_reg;
        sj_ok_next    = sj_ok_reg;

        if (step.valid && step.kind == ted_pkg::KIND_END) begin
            // end of text: back to reset state
            bom_cnt_next  = 2'd0;
            bom_ok_next   = 1'b1;
            u8_pend_next  = 2'd0;
            u8_lo_next    = ted_pkg::CONT_LO;
            u8_hi_next    = ted_pkg::CONT_HI;
            u8_ok_next    = 1'b1;
            sj_trail_next = 1'b0;
            sj_ok_next    = 1'b1;
        end else if (step.valid) begin
            // byte order mark
            if (bom_ok_reg && bom_cnt_reg != 2'(ted_pkg::BOM_LEN)) begin
                if (b == ted_pkg::bom_byte(bom_cnt_reg)) begin
                    bom_cnt_next = bom_cnt_reg + 2'd1;
                end else begin
                    bom_ok_next = 1'b0;
                end
            end

            // strict UTF-8
            if (u8_ok_reg) begin
                if (u8_pend_reg != 2'd0) begin
                    u8_lo_next = ted_pkg::CONT_LO;
                    u8_hi_next = ted_pkg::CONT_HI;
                    if (b < u8_lo_reg || b > u8_hi_reg) begin
                        u8_ok_next   = 1'b0;
                        u8_pend_next = 2'd0;
                    end else begin
                        u8_pend_next = u8_pend_reg - 2'd1;
                    end
                end else if (b <= 8'h7F) begin
                    // ASCII, nothing to do
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    u8_pend_next = 2'd1;
                    u8_lo_next   = ted_pkg::CONT_LO;
                    u8_hi_next   = ted_pkg::CONT_HI;
                end else if (b == 8'hE0) begin
                    // no overlong three-byte forms
                    u8_pend_next = 2'd2;
                    u8_lo_next   = 8'hA0;
                    u8_hi_next   = ted_pkg::CONT_HI;
                end else if (b == 8'hED) begin
                    // no surrogates
                    u8_pend_next = 2'd2;
                    u8_lo_next   = ted_pkg::CONT_LO;
                    u8_hi_next   = 8'h9F;
                end else if (b >= 8'hE1 && b <= 8'hEF) begin
                    u8_pend_next = 2'd2;
                    u8_lo_next   = ted_pkg::CONT_LO;
                    u8_hi_next   = ted_pkg::CONT_HI;
                end else if (b == 8'hF0) begin
                    // no overlong four-byte forms
                    u8_pend_next = 2'd3;
                    u8_lo_next   = 8'h90;
                    u8_hi_next   = ted_pkg::CONT_HI;
                end else if (b >= 8'hF1 && b <= 8'hF3) begin
                    u8_pend_next = 2'd3;
                    u8_lo_next   = ted_pkg::CONT_LO;
                    u8_hi_next   = ted_pkg::CONT_HI;
                end else if (b == 8'hF4) begin
                    // cap at 10FFFF
                    u8_pend_next = 2'd3;
                    u8_lo_next   = ted_pkg::CONT_LO;
                    u8_hi_next   = 8'h8F;
                end else begin
                    u8_ok_next = 1'b0;
                end
            end

            // CP932 byte shape
            if (sj_ok_reg) begin
                if (sj_trail_reg) begin
                    if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
                        sj_trail_next = 1'b0;
                    end else begin
                        sj_ok_next = 1'b0;
                    end
                end else if (b <= 8'h7F || (b >= 8'hA1 && b <= 8'hDF)) begin
                    // single-byte character
                end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
                    sj_trail_next = 1'b1;
                end else begin
                    sj_ok_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bom_cnt_reg  <= 2'd0;
            bom_ok_reg   <= 1'b1;
            u8_pend_reg  <= 2'd0;
            u8_lo_reg    <= ted_pkg::CONT_LO;
            u8_hi_reg    <= ted_pkg::CONT_HI;
            u8_ok_reg    <= 1'b1;
            sj_trail_reg <= 1'b0;
            sj_ok_reg    <= 1'b1;
        end else begin
            bom_cnt_reg  <= bom_cnt_next;
            bom_ok_reg   <= bom_ok_next;
            u8_pend_reg  <= u8_pend_next;
            u8_lo_reg    <= u8_lo_next;
            u8_hi_reg    <= u8_hi_next;
            u8_ok_reg    <= u8_ok_next;
            sj_trail_reg <= sj_trail_next;
            sj_ok_reg    <= sj_ok_next;
        end
    end

    // Verdict from the state reached so far
    assign has_bom   = bom_ok_reg && bom_cnt_reg == 2'(ted_pkg::BOM_LEN);
    assign utf8_good = u8_ok_reg && u8_pend_reg == 2'd0;
    assign sjis_good = sj_ok_reg && !sj_trail_reg;

    always_comb begin
        if (utf8_good) begin
            verdict = has_bom ? ted_pkg::VERDICT_UTF8_BOM : ted_pkg::VERDICT_UTF8;
        end else if (has_bom) begin
            verdict = ted_pkg::VERDICT_UNDECOD;
        end else begin
            verdict = sjis_good ? ted_pkg::VERDICT_SJIS : ted_pkg::VERDICT_UNDECOD;
        end
    end

endmodule

>>> hw/rtl/text_encoding_detector_unit.sv
// Text encoding detector. Feed a text one byte per word (s_tuser = 0, byte in
// s_tdata), then one end-of-text word (s_tuser = 1, s_tdata ignored). Only the
// end-of-text word produces a result: m_tdata[1:0] = 0 UTF-8, 1 UTF-8 with
// byte order mark, 2 CP932 double-byte text, 3 undecodable. UTF-8 is checked
// strictly (no overlong forms, surrogates or code points above 10FFFF). A data
// word is taken every cycle while no end-of-text word waits; an end-of-text
// word waits in the input register only while a previous verdict sits unread
// in the result register. An accepted end-of-text word passes the input
// register; as it retires, the verdict from the scanner state is loaded into
// the result register and offered on m_tvalid. After each end-of-text word the
// detector starts fresh for the next text.
module text_encoding_detector_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);

    `include "text_encoding_detector_unit_defines.svh"

    logic              in_valid_reg;
    ted_pkg::kind_t    in_kind_reg;
    logic [7:0]        in_byte_reg;
    logic              m_valid_reg;
    ted_pkg::verdict_t m_verdict_reg;

    logic              advance;
    logic              end_advance;
    ted_pkg::step_t    step;
    ted_pkg::verdict_t verdict;

    // Input word retires unless it is an end-of-text word facing a full output
    assign advance     = in_valid_reg &&
                         (in_kind_reg == ted_pkg::KIND_DATA || !m_valid_reg || m_tready);
    assign end_advance = advance && in_kind_reg == ted_pkg::KIND_END;
    assign s_tready    = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= ted_pkg::kind_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    assign step.valid     = advance;
    assign step.kind      = in_kind_reg;
    assign step.data_byte = in_byte_reg;

    ted_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .verdict (verdict)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (end_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_advance) begin
            m_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_verdict_reg};

    // Checks
    `TED_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, in_valid_reg,
        "accepted word missing from input register")
    `TED_ASSERT_NEXT(a_end_gives_result, end_advance, m_valid_reg,
        "end of text did not load a result")
    `TED_ASSERT_NEXT(a_end_waits,
        in_valid_reg && in_kind_reg == ted_pkg::KIND_END && m_valid_reg && !m_tready,
        in_valid_reg && in_kind_reg == ted_pkg::KIND_END,
        "end-of-text word dropped while output stalled")
    `TED_ASSERT_NOW(a_data_flows, in_valid_reg && in_kind_reg == ted_pkg::KIND_DATA,
        s_tready, "data word blocked the input")

endmodule
